FILE: src/pst_pkg.sv
// Shared constants and types for the PS/2 key state tracker.
package pst_pkg;

   // Number of map entries that are searched (1 to 8).
   localparam int MAP_ENTRIES = 8;

   // Fixed field widths.
   localparam int CODE_W  = 8;
   localparam int FLAGS_W = 8;
   localparam int MAP_W   = FLAGS_W * CODE_W;

   // Special scancode values.
   localparam logic [CODE_W-1:0] BREAK_CODE    = 8'hF0;
   localparam logic [CODE_W-1:0] LIST_END_CODE = 8'hFF;

   // Reset value of the map: an empty list.
   localparam logic [MAP_W-1:0] MAP_RESET = '1;

   // Result of comparing one byte against the active map entries.
   typedef struct packed {
      logic [FLAGS_W-1:0] mask;
      logic               nonempty;
   } match_type;

   // Architectural tracker state.
   typedef struct packed {
      logic               release_pending;
      logic [FLAGS_W-1:0] key_flags;
      logic [CODE_W-1:0]  pressed_code;
      logic [CODE_W-1:0]  typed_code;
   } state_type;

endpackage

FILE: src/ps2_key_state_tracker_unit.sv
// Top level of the PS/2 key state tracker: handshakes, map register, result register.
// The input register feeds the update; the eight map compares sit in one stage, and the
// result register loads when a transaction leaves the input register.
// Throughput: one scancode per cycle while rsp_ready drains the result register.
// Reset: synchronous; clears key flags and both codes, empties the map (all ones).
module ps2_key_state_tracker_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [pst_pkg::CODE_W-1:0]  req_scan_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pst_pkg::FLAGS_W-1:0] rsp_key_bits,
   output logic [pst_pkg::CODE_W-1:0]  rsp_last_pressed,
   output logic [pst_pkg::CODE_W-1:0]  rsp_last_typed,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pst_pkg::MAP_W-1:0]   csr_map_codes
);
   import pst_pkg::*;

   logic               in_valid_ff;
   logic [CODE_W-1:0]  in_byte_ff;
   logic               out_valid_ff;
   state_type          out_ff;
   logic [MAP_W-1:0]   map_ff;
   logic               advance;
   state_type          state_cur;
   state_type          state_next;

   // A transaction moves on when the result register is free or being drained.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Map register.
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff <= MAP_RESET;
      end else if (csr_valid) begin
         map_ff <= csr_map_codes;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_scan_byte;
      end
   end

   pst_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .code       (in_byte_ff),
      .map_codes  (map_ff),
      .state_cur  (state_cur),
      .state_next (state_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= state_next;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_key_bits     = out_ff.key_flags;
   assign rsp_last_pressed = out_ff.pressed_code;
   assign rsp_last_typed   = out_ff.typed_code;

   // Every transaction that leaves the input register yields a result next cycle.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result missing after update");

   // A break prefix leaves key flags and both codes untouched.
   a_break_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (advance && in_byte_ff == BREAK_CODE) |=>
         (rsp_key_bits == $past(state_cur.key_flags) &&
          rsp_last_pressed == $past(state_cur.pressed_code) &&
          rsp_last_typed == $past(state_cur.typed_code)))
      else $error("break prefix changed state");

   // With an empty map no key flag is set and the pressed code is kept.
   a_empty_map_keeps: assert property (@(posedge clock) disable iff (reset)
      (advance && map_ff[CODE_W-1:0] == LIST_END_CODE) |=>
         (rsp_key_bits == ($past(state_cur.key_flags) & rsp_key_bits) &&
          rsp_last_pressed == $past(state_cur.pressed_code)))
      else $error("empty map altered flags or pressed code");

   // Right after reset the pipeline is empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

endmodule

FILE: src/pst_match.sv
// Parallel compare of one scancode against the active map entries.
module pst_match (
   input  logic [pst_pkg::CODE_W-1:0] code,
   input  logic [pst_pkg::MAP_W-1:0]  map_codes,
   output pst_pkg::match_type         result
);
   import pst_pkg::*;

   // Walk the entries in order; the first list-end code cuts the list short.
   always_comb begin
      logic              alive;
      logic [CODE_W-1:0] entry;
      alive  = 1'b1;
      result = '0;
      for (int i = 0; i < MAP_ENTRIES; i++) begin
         entry = map_codes[i*CODE_W +: CODE_W];
         if (entry == LIST_END_CODE) begin
            alive = 1'b0;
         end
         if (alive) begin
            result.nonempty = 1'b1;
            result.mask[i]  = (entry == code);
         end
      end
   end

endmodule

FILE: src/pst_core.sv
// Tracker state registers and the combinational update for one scancode.
module pst_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic [pst_pkg::CODE_W-1:0] code,
   input  logic [pst_pkg::MAP_W-1:0]  map_codes,
   output pst_pkg::state_type         state_cur,
   output pst_pkg::state_type         state_next
);
   import pst_pkg::*;

   state_type state_ff;
   state_type state_in;
   match_type match;

   pst_match u_match (
      .code      (code),
      .map_codes (map_codes),
      .result    (match)
   );

   // Decode the byte as break prefix, release code or make code.
   always_comb begin
      state_in = state_ff;
      if (code == BREAK_CODE) begin
         state_in.release_pending = 1'b1;
      end else if (state_ff.release_pending) begin
         state_in.release_pending = 1'b0;
         state_in.key_flags       = state_ff.key_flags & ~match.mask;
         if (code == state_ff.pressed_code) begin
            state_in.typed_code = code;
         end
      end else begin
         state_in.key_flags = state_ff.key_flags | match.mask;
         if (match.nonempty) begin
            state_in.pressed_code = code;
         end
      end
   end

   // State updates when a transaction leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign state_cur  = state_ff;
   assign state_next = state_in;

endmodule
